/* hw/rtl/owsm_pkg.sv */
// Shared types and constants for the 1-Wire slot master.
// Used by owsm_cfg, owsm_step and one_wire_slot_master.
package owsm_pkg;

  localparam int REG_W = 16;
  localparam int IDX_W = 3;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_RESET = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;
  localparam logic [1:0] PH_READ  = 2'd3;

  localparam logic [IDX_W-1:0] REG_SLOT      = 3'd0;
  localparam logic [IDX_W-1:0] REG_ONE_LOW   = 3'd1;
  localparam logic [IDX_W-1:0] REG_ZERO_LOW  = 3'd2;
  localparam logic [IDX_W-1:0] REG_READ_THR  = 3'd3;
  localparam logic [IDX_W-1:0] REG_RST_SLOT  = 3'd4;
  localparam logic [IDX_W-1:0] REG_RST_LOW   = 3'd5;
  localparam logic [IDX_W-1:0] REG_PRES_THR  = 3'd6;

  typedef struct packed {
    logic [REG_W-1:0] slot_ticks;
    logic [REG_W-1:0] one_low_ticks;
    logic [REG_W-1:0] zero_low_ticks;
    logic [REG_W-1:0] read_threshold_ticks;
    logic [REG_W-1:0] reset_slot_ticks;
    logic [REG_W-1:0] reset_low_ticks;
    logic [REG_W-1:0] presence_threshold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] tx_byte;
    logic [3:0] bit_count;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } res_t;

endpackage

/* hw/rtl/one_wire_slot_master.sv */
// 1-Wire slot master, top level: stream ports, input and result registers.
// Depends on owsm_pkg, owsm_cfg and owsm_step.
// An accepted tick goes from the input register through the step logic into the result register.
// Throughput: one tick per clock cycle while m_tready does not stall the master side; the step logic is combinational.
// Reset (rst, synchronous): bus state idle with the line level taken as high,
// timing registers back to their defaults, both stream registers empty.
module one_wire_slot_master #(
  parameter int TICK_WIDTH = 16,
  parameter int MAX_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] command, [9:2] tx_byte, [13:10] bit_count, [14] line_level, [15] zero
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [10:3] rx_byte, [11] status,
  // [15:12] zero
  output logic [15:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [owsm_pkg::IDX_W-1:0] cfg_index,
  input  logic [owsm_pkg::REG_W-1:0] cfg_data
);
  import owsm_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  logic  in_valid;
  res_t  step_res, out_res;
  logic  advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;

  owsm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  owsm_step #(
    .TICK_WIDTH (TICK_WIDTH),
    .MAX_BITS   (MAX_BITS)
  ) u_step (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .cfg  (cfg),
    .item (in_item),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.command    <= s_tdata[1:0];
      in_item.tx_byte    <= s_tdata[9:2];
      in_item.bit_count  <= s_tdata[13:10];
      in_item.line_level <= s_tdata[14];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tdata = {4'b0, out_res.status, out_res.rx_byte, out_res.done_res,
                    out_res.busy_res, out_res.drive_low};

endmodule

/* hw/rtl/owsm_cfg.sv */
// Timing register file of the 1-Wire slot master.
// Depends on owsm_pkg for the register indexes and cfg_t.
module owsm_cfg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [owsm_pkg::IDX_W-1:0] wr_index,
  input  logic [owsm_pkg::REG_W-1:0] wr_data,
  output owsm_pkg::cfg_t          cfg
);
  import owsm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_ticks               <= 16'd70;
      cfg.one_low_ticks            <= 16'd6;
      cfg.zero_low_ticks           <= 16'd60;
      cfg.read_threshold_ticks     <= 16'd15;
      cfg.reset_slot_ticks         <= 16'd960;
      cfg.reset_low_ticks          <= 16'd480;
      cfg.presence_threshold_ticks <= 16'd550;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SLOT:     cfg.slot_ticks               <= wr_data;
        REG_ONE_LOW:  cfg.one_low_ticks            <= wr_data;
        REG_ZERO_LOW: cfg.zero_low_ticks           <= wr_data;
        REG_READ_THR: cfg.read_threshold_ticks     <= wr_data;
        REG_RST_SLOT: cfg.reset_slot_ticks         <= wr_data;
        REG_RST_LOW:  cfg.reset_low_ticks          <= wr_data;
        REG_PRES_THR: cfg.presence_threshold_ticks <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/owsm_step.sv */
// Per-tick slot sequencer: bus state and the combinational step for one tick.
// Depends on owsm_pkg for phase codes, cfg_t, item_t and res_t.
module owsm_step #(
  parameter int TICK_WIDTH = 16,
  parameter int MAX_BITS   = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  owsm_pkg::cfg_t  cfg,
  input  owsm_pkg::item_t item,
  output owsm_pkg::res_t  res
);
  import owsm_pkg::*;

  localparam int CW = (TICK_WIDTH > REG_W) ? TICK_WIDTH : REG_W;
  localparam int LW = $clog2(MAX_BITS + 1);
  localparam int PW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

  logic [1:0]            phase, phase_next;
  logic [TICK_WIDTH-1:0] slot_tick, slot_tick_next;
  logic [PW-1:0]         bit_position, bit_position_next;
  logic [LW-1:0]         bits_left, bits_left_next;
  logic [MAX_BITS-1:0]   send_shift, send_shift_next;
  logic [MAX_BITS-1:0]   receive_shift, receive_shift_next;
  logic [CW-1:0]         last_rise_tick, last_rise_tick_next;
  logic                  previous_level;

  always_comb begin
    logic          rising, active, early, slot_end;
    logic [1:0]    ph;
    logic [3:0]    cnt;
    logic [REG_W-1:0] len, low, thr;
    logic [CW-1:0] t_ext, lrt;
    logic [CW:0]   t_inc;
    logic [LW-1:0] left_dec;

    rising = item.line_level & ~previous_level;
    phase_next          = phase;
    slot_tick_next      = slot_tick;
    bit_position_next   = bit_position;
    bits_left_next      = bits_left;
    send_shift_next     = send_shift;
    receive_shift_next  = receive_shift;
    last_rise_tick_next = last_rise_tick;
    res = '0;
    active = 1'b0;
    ph = phase;
    cnt = item.bit_count;
    early = 1'b0;

    if (phase == PH_IDLE) begin
      if (item.command == PH_RESET) begin
        cnt = 4'd1;
        active = 1'b1;
      end else if (item.command != PH_IDLE) begin
        if (cnt == 4'd0) begin
          res.done_res = 1'b1;
        end else begin
          active = 1'b1;
          if (cnt > 4'(MAX_BITS)) begin
            cnt = 4'(MAX_BITS);
          end
        end
      end
      if (active) begin
        ph = item.command;
        slot_tick_next     = '0;
        bit_position_next  = '0;
        bits_left_next     = LW'(cnt);
        send_shift_next    = MAX_BITS'(item.tx_byte);
        receive_shift_next = '0;
        last_rise_tick_next = (ph == PH_RESET) ? CW'(cfg.reset_slot_ticks)
                                               : CW'(cfg.slot_ticks);
      end
    end else begin
      active = 1'b1;
    end

    len = (ph == PH_RESET) ? cfg.reset_slot_ticks : cfg.slot_ticks;
    case (ph)
      PH_RESET: begin
        low = cfg.reset_low_ticks;
        thr = cfg.presence_threshold_ticks;
      end
      PH_WRITE: begin
        low = send_shift_next[bit_position_next] ? cfg.one_low_ticks : cfg.zero_low_ticks;
        thr = cfg.read_threshold_ticks;
      end
      default: begin
        low = cfg.one_low_ticks;
        thr = cfg.read_threshold_ticks;
      end
    endcase

    t_ext = CW'(slot_tick_next);
    t_inc = {1'b0, t_ext} + (CW+1)'(1);
    lrt = rising ? t_ext : last_rise_tick_next;
    slot_end = (t_inc >= (CW+1)'(len)) || (&slot_tick_next);
    left_dec = bits_left_next - LW'(1);

    if (active) begin
      phase_next = ph;
      res.busy_res  = 1'b1;
      res.drive_low = (t_ext < CW'(low));
      last_rise_tick_next = lrt;
      if (slot_end) begin
        early = (lrt < CW'(thr));
        if ((ph == PH_READ) && early) begin
          receive_shift_next[bit_position_next] = 1'b1;
        end
        bits_left_next    = left_dec;
        bit_position_next = bit_position_next + PW'(1);
        slot_tick_next    = '0;
        if (left_dec == '0) begin
          res.done_res = 1'b1;
          phase_next   = PH_IDLE;
          if (ph == PH_READ) begin
            res.rx_byte = 8'(receive_shift_next);
          end else if (ph == PH_RESET) begin
            res.status = early;
          end
        end else begin
          last_rise_tick_next = CW'(len);
        end
      end else begin
        slot_tick_next = t_inc[TICK_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      slot_tick      <= '0;
      bit_position   <= '0;
      bits_left      <= '0;
      send_shift     <= '0;
      receive_shift  <= '0;
      last_rise_tick <= '0;
      previous_level <= 1'b1;
    end else if (en) begin
      phase          <= phase_next;
      slot_tick      <= slot_tick_next;
      bit_position   <= bit_position_next;
      bits_left      <= bits_left_next;
      send_shift     <= send_shift_next;
      receive_shift  <= receive_shift_next;
      last_rise_tick <= last_rise_tick_next;
      previous_level <= item.line_level;
    end
  end

endmodule
